[rtl/core/ira_pkg.sv]
// Shared constants, widths and the digit-to-character function of the radix converter.
`default_nettype none

package ira_pkg;

  // Width of the value being converted and size of the digit store.
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned DIGIT_SLOTS = 32;

  // Radix and digit widths. A digit is always below the radix, so both share a width.
  localparam int unsigned RADIX_BITS = 6;
  localparam int unsigned DIGIT_BITS = RADIX_BITS;
  localparam int unsigned CHAR_BITS  = 8;

  // Digit store addressing and a count that can also hold the full store size.
  localparam int unsigned IDX_BITS = $clog2(DIGIT_SLOTS);
  localparam int unsigned CNT_BITS = $clog2(DIGIT_SLOTS + 1);

  // The shared divider retires this many quotient bits per cycle.
  localparam int unsigned BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_CYCLES     = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned PAD_BITS       = DIV_CYCLES * BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

  // Radix limits and the one radix that gets a sign.
  localparam logic [RADIX_BITS-1:0] RADIX_MIN    = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX    = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] DECIMAL_BASE = RADIX_BITS'(10);

  // ASCII codes.
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS   = 8'h2D;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] ASCII_LOWER_Z = 8'h7A;

  // Map a digit to '0'..'9' or 'a'..'z'.
  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DECIMAL_BASE) begin
      c = CHAR_BITS'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_BITS'(d) - CHAR_BITS'(DECIMAL_BASE) + ASCII_LOWER_A;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/integer_to_radix_ascii_top.sv]
// Top level of the integer to radix ASCII converter.
// Each digit comes from the shared divider (8 quotient bits per cycle over 32 bits); its remainder
// is stored and the divider is restarted on the quotient until the quotient is zero.
// Characters follow once all digits are divided; busy_o drops with the last character.
// One item at a time; a minus sign, if any, comes before the digits.
// Asynchronous active-low reset returns the sequencer to idle with no strobe pending.
`default_nettype none

module integer_to_radix_ascii_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  wire logic signed [ira_pkg::VALUE_BITS-1:0] value_i,
  input  wire logic [ira_pkg::RADIX_BITS-1:0]      radix_i,
  output      logic                                strobe_o,
  output      logic [ira_pkg::CHAR_BITS-1:0]       character_o,
  output      logic                                last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  state_e                             state_q;
  logic [ira_pkg::RADIX_BITS-1:0]     radix_q;
  logic                               sign_q;
  logic [ira_pkg::CNT_BITS-1:0]       cnt_q;
  logic                               strobe_q;
  logic [ira_pkg::CHAR_BITS-1:0]      char_q;
  logic                               last_q;

  logic [ira_pkg::DIGIT_BITS-1:0]     digit_q [ira_pkg::DIGIT_SLOTS];

  logic [ira_pkg::RADIX_BITS-1:0]     radix_c;
  logic [ira_pkg::VALUE_BITS-1:0]     value_u;
  logic [ira_pkg::VALUE_BITS-1:0]     mag_in;
  logic                               neg_in;
  logic                               accept;
  logic                               more;
  logic [ira_pkg::CNT_BITS-1:0]       cnt_inc;
  logic [ira_pkg::IDX_BITS-1:0]       rd_idx;

  logic                               div_start;
  logic [ira_pkg::VALUE_BITS-1:0]     div_dividend;
  logic [ira_pkg::RADIX_BITS-1:0]     div_divisor;
  logic                               div_done;
  logic [ira_pkg::VALUE_BITS-1:0]     div_quo;
  logic [ira_pkg::DIGIT_BITS-1:0]     div_rem;

  // Clamp the radix and work out sign and magnitude of the incoming value.
  always_comb begin
    radix_c = radix_i;
    if (radix_i < ira_pkg::RADIX_MIN) begin
      radix_c = ira_pkg::RADIX_MIN;
    end else if (radix_i > ira_pkg::RADIX_MAX) begin
      radix_c = ira_pkg::RADIX_MAX;
    end
  end

  assign value_u = value_i;
  assign neg_in  = (radix_c == ira_pkg::DECIMAL_BASE) && value_u[ira_pkg::VALUE_BITS-1];
  assign mag_in  = neg_in ? (ira_pkg::VALUE_BITS'(0) - value_u) : value_u;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign cnt_inc = cnt_q + ira_pkg::CNT_BITS'(1);
  assign more    = (div_quo != '0) && (cnt_inc < ira_pkg::CNT_BITS'(ira_pkg::DIGIT_SLOTS));
  assign rd_idx  = ira_pkg::IDX_BITS'(cnt_q - ira_pkg::CNT_BITS'(1));

  // Start the divider on the input beat and again after every digit while the quotient lasts.
  assign div_start    = accept || ((state_q == ST_DIVIDE) && div_done && more);
  assign div_dividend = (state_q == ST_IDLE) ? mag_in : div_quo;
  assign div_divisor  = (state_q == ST_IDLE) ? radix_c : radix_q;

  ira_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Digit store, least significant digit first.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIVIDE) && div_done) begin
      digit_q[cnt_q[ira_pkg::IDX_BITS-1:0]] <= div_rem;
    end
  end

  // Sequencer with the registered output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      radix_q  <= '0;
      sign_q   <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          strobe_q <= 1'b0;
          if (start_i) begin
            radix_q <= radix_c;
            sign_q  <= neg_in;
            cnt_q   <= '0;
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          strobe_q <= 1'b0;
          if (div_done) begin
            cnt_q <= cnt_inc;
            if (!more) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          strobe_q <= 1'b1;
          if (sign_q) begin
            char_q <= ira_pkg::ASCII_MINUS;
            last_q <= 1'b0;
            sign_q <= 1'b0;
          end else begin
            char_q <= ira_pkg::digit_to_ascii(digit_q[rd_idx]);
            last_q <= (cnt_q == ira_pkg::CNT_BITS'(1));
            cnt_q  <= cnt_q - ira_pkg::CNT_BITS'(1);
            if (cnt_q == ira_pkg::CNT_BITS'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q  <= ST_IDLE;
          strobe_q <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[rtl/core/ira_divider.sv]
// Iterative divider: splits a value by a small radix into quotient and remainder.
`default_nettype none

module ira_divider (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [ira_pkg::VALUE_BITS-1:0]     dividend_i,
  input  wire logic [ira_pkg::RADIX_BITS-1:0]     divisor_i,
  output      logic                               done_o,
  output      logic [ira_pkg::VALUE_BITS-1:0]     quotient_o,
  output      logic [ira_pkg::DIGIT_BITS-1:0]     remainder_o
);

  logic [ira_pkg::PAD_BITS-1:0]     work_q, work_d;
  logic [ira_pkg::DIGIT_BITS-1:0]   rem_q, rem_d;
  logic [ira_pkg::RADIX_BITS-1:0]   div_q;
  logic [ira_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic                             run_q;
  logic                             done_q;
  logic                             last_step;

  // Restoring division, several quotient bits per cycle. The work register shifts
  // the dividend out at the top and collects quotient bits at the bottom.
  always_comb begin
    logic [ira_pkg::DIGIT_BITS:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < int'(ira_pkg::BITS_PER_CYCLE); i++) begin
      trial  = {rem_d, work_d[ira_pkg::PAD_BITS-1]};
      work_d = {work_d[ira_pkg::PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial     = trial - {1'b0, div_q};
        work_d[0] = 1'b1;
      end
      rem_d = trial[ira_pkg::DIGIT_BITS-1:0];
    end
  end

  assign last_step = (cnt_q == ira_pkg::DIV_CNT_BITS'(ira_pkg::DIV_CYCLES - 1));

  // Sequencer: a start loads new operands and has priority over a running division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q  <= cnt_q + ira_pkg::DIV_CNT_BITS'(1);
      run_q  <= !last_step;
      done_q <= last_step;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= ira_pkg::PAD_BITS'(dividend_i);
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[ira_pkg::VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[rtl/core/ira_checker.sv]
// Port-level checker for the radix converter and its bind to the top level.
`default_nettype none

module ira_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  start_i,
  input wire logic                                  busy_o,
  input wire logic                                  strobe_o,
  input wire logic [ira_pkg::CHAR_BITS-1:0]         character_o,
  input wire logic                                  last_o
);

  // An accepted input beat makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy did not rise after an accepted start");

  // Characters of one number come in consecutive cycles until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside the characters of one number");

  // The block stays busy while characters of the number are still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy_o)
    else $error("block idle before the last character");

  // The last character ends the output beats of the number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("character beat right after the last character");

  // Only a minus sign, a decimal digit or a lower-case letter is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ((character_o == ira_pkg::ASCII_MINUS) ||
                  ((character_o >= ira_pkg::ASCII_ZERO) &&
                   (character_o <= ira_pkg::ASCII_NINE)) ||
                  ((character_o >= ira_pkg::ASCII_LOWER_A) &&
                   (character_o <= ira_pkg::ASCII_LOWER_Z))))
    else $error("character outside the digit alphabet");

endmodule

bind integer_to_radix_ascii_top ira_checker u_ira_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .strobe_o    (strobe_o),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire
